// ===== rtl/rtt_pkg.sv =====
// package for the repeating timer table: constants and shared types
package rtt_pkg;
  localparam int DefaultDepth = 16;
  localparam int MaxResults = 16;

  typedef enum logic [1:0] {
    ST_FIRED = 2'd0,
    ST_ADDED = 2'd1,
    ST_FULL  = 2'd2,
    ST_IDLE  = 2'd3
  } status_t;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // one table entry
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [31:0] delay;
    logic [31:0] last_call;
    logic [15:0] calls_made;
    logic [15:0] limit;
  } entry_t;
endpackage

// ===== rtl/repeating_timer_table.sv =====
// top level of the repeating timer table
//
// usage:
//   one input channel (valid/ready) carries requests: command 0 adds a timer,
//   command 1 ticks at now_time. one output channel (valid/ready) carries
//   result requests with status, fired_handle, fired_kind and last.
//   an add gives one result in the cycle after acceptance; ready returns in
//   the cycle after that result is taken.
//   a tick walks the stored entries once per kind 0..7 through a single
//   shared due unit, reading then testing each entry for each kind, then
//   compacts the table, reading then moving each entry. a tick on an empty
//   table gives one result with idle status.
//   at most 16 firings are reported per tick.
//   each firing is held until the next one is found, so its last flag is
//   known; the final result comes out after the compaction pass.
//   the block holds ready low for the whole of one request.
//   a stalled receiver stops the walk for as long as out_ready is low
//   while a result is shown.
//   reset empties the table (count to zero); stored entries are not cleared.
//   entries live in one memory written and read one address per cycle.
module repeating_timer_table #(
  parameter int TABLE_DEPTH = rtt_pkg::DefaultDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] now_time,
  input  logic [2:0]  timer_kind,
  input  logic [15:0] callback_handle,
  input  logic [31:0] delay_ticks,
  input  logic signed [15:0] call_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] fired_handle,
  output logic [2:0]  fired_kind,
  output logic        last
);
  import rtt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_TEST, S_CREAD, S_CMOVE, S_OUT
  } state_t;

  state_t state;
  entry_t mem [TABLE_DEPTH];
  logic   rm  [TABLE_DEPTH];    // remove marks
  entry_t rd;                   // registered read data
  logic [IW-1:0] idx;           // walk index
  logic [IW-1:0] wr;            // compaction write index
  logic [CW-1:0] count;
  logic [2:0]    kind_cur;
  logic [RW-1:0] nres;
  logic [31:0]   now_q;
  logic          final_out;     // result shown is the last one
  logic          hold_valid;    // a firing is waiting for its last flag
  logic [15:0]   hold_handle;
  logic [2:0]    hold_kind;

  logic   due, expire;
  entry_t upd;
  rtt_due_unit u_due (.ent(rd), .now_time(now_q), .due(due), .expire(expire), .upd(upd));

  // write port control
  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;

  logic last_idx;
  logic walk_end;
  logic fire;
  assign last_idx = (CW'(idx) == count - CW'(1));
  assign walk_end = last_idx && (kind_cur == 3'd7);
  assign fire     = (rd.kind == kind_cur) && due && (nres < RW'(MaxResults));

  always_comb begin
    we = 1'b0; waddr = idx; wdata = upd;
    if (state == S_IDLE && in_valid && command == CMD_ADD && count < CW'(TABLE_DEPTH)) begin
      we = 1'b1;
      waddr = count[IW-1:0];
      wdata.kind = timer_kind;
      wdata.handle = callback_handle;
      wdata.delay = delay_ticks;
      wdata.last_call = now_time;
      wdata.calls_made = '0;
      wdata.limit = (call_limit == 16'sd0) ? 16'd1 : call_limit;
    end else if (state == S_TEST && fire) begin
      we = 1'b1;
    end else if (state == S_CMOVE && !rm[idx]) begin
      we = 1'b1; waddr = wr; wdata = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[idx];
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
      idx <= '0;
      hold_valid <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) rm[i] <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          now_q <= now_time;
          idx <= '0; wr <= '0; kind_cur <= '0; nres <= '0;
          hold_valid <= 1'b0;
          for (int i = 0; i < TABLE_DEPTH; i++) rm[i] <= 1'b0;
          if (command == CMD_ADD) begin
            out_valid <= 1'b1; last <= 1'b1;
            final_out <= 1'b1;
            state <= S_OUT;
            if (count < CW'(TABLE_DEPTH)) begin
              count <= count + CW'(1);
              status <= ST_ADDED;
              fired_handle <= callback_handle;
              fired_kind <= timer_kind;
            end else begin
              status <= ST_FULL; fired_handle <= '0; fired_kind <= '0;
            end
          end else if (count == '0) begin
            out_valid <= 1'b1; last <= 1'b1; final_out <= 1'b1;
            status <= ST_IDLE; fired_handle <= '0; fired_kind <= '0;
            state <= S_OUT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_TEST;   // read data lands in rd
        S_TEST: begin
          state <= walk_end ? S_CREAD : S_READ;
          if (fire) begin
            nres <= nres + RW'(1);
            if (expire) rm[idx] <= 1'b1;
            // the earlier firing is now known not to be the last
            if (hold_valid) begin
              out_valid <= 1'b1; last <= 1'b0; final_out <= 1'b0;
              status <= ST_FIRED; fired_handle <= hold_handle; fired_kind <= hold_kind;
              state <= S_OUT;
            end
            hold_valid <= 1'b1;
            hold_handle <= rd.handle;
            hold_kind <= rd.kind;
          end
          // advance walk position
          if (last_idx) begin
            idx <= '0;
            kind_cur <= kind_cur + 3'd1;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_CREAD: state <= S_CMOVE;
        S_CMOVE: begin
          if (!rm[idx]) wr <= wr + IW'(1);
          if (last_idx) begin
            count <= CW'(wr) + CW'(!rm[idx]);
            out_valid <= 1'b1; last <= 1'b1; final_out <= 1'b1;
            // held firing closes the tick, else nothing was due
            if (hold_valid) begin
              status <= ST_FIRED; fired_handle <= hold_handle; fired_kind <= hold_kind;
            end else begin
              status <= ST_IDLE; fired_handle <= '0; fired_kind <= '0;
            end
            state <= S_OUT;
          end else begin
            idx <= idx + IW'(1);
            state <= S_CREAD;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          if (final_out) state <= S_IDLE;
          else if (idx == '0 && kind_cur == 3'd0) state <= S_CREAD;  // walk done
          else state <= S_READ;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(TABLE_DEPTH))
    else $error("count above depth");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("result outside output state");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("ready while result held");
endmodule

// ===== rtl/rtt_due_unit.sv =====
// shared due test and entry update for one table entry
module rtt_due_unit (
  input  rtt_pkg::entry_t ent,
  input  logic [31:0]     now_time,
  output logic            due,
  output logic            expire,
  output rtt_pkg::entry_t upd
);
  import rtt_pkg::*;
  logic [31:0] elapsed;
  logic [15:0] calls_inc;

  assign elapsed   = now_time - ent.last_call;
  assign due       = elapsed >= ent.delay;
  assign calls_inc = (ent.calls_made == 16'hffff) ? ent.calls_made : ent.calls_made + 16'd1;

  always_comb begin
    upd = ent;
    upd.last_call  = now_time;
    upd.calls_made = calls_inc;
  end

  // bit 15 clear means a finite limit
  assign expire = !ent.limit[15] && (calls_inc >= ent.limit);
endmodule
